// ----- sv/pstfe_pkg.sv -----
// package for the probed slot table: sizes, status codes and the
// command/status structs shared by the controller and the datapath
// no dependencies
`default_nettype none

package pstfe_pkg;

  // table geometry (slot count is a power of two: the home slot is the low key bits)
  localparam int SLOT_COUNT   = 256;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int PROBE_WINDOW = 8;
  localparam int CNT_W        = (PROBE_WINDOW > 1) ? $clog2(PROBE_WINDOW) : 1;

  // field widths
  localparam int KEY_W   = 32;
  localparam int STAMP_W = 32;
  localparam int IDX_W   = 8;
  localparam int STS_W   = 2;

  // stream widths
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 16;

  typedef enum logic [STS_W-1:0] {
    STS_HIT   = 2'd0,
    STS_CLAIM = 2'd1,
    STS_FULL  = 2'd2,
    STS_FRAME = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FRAME  = 1'b1
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic start;  // take the input transfer
    logic step;   // evaluate one probed slot
    logic emit;   // move the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic direct;    // input needs no walk: frame advance or zero key
    logic done;      // the walk has decided this cycle
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage : pstfe_pkg

`default_nettype wire

// ----- sv/probed_slot_table_frame_evict_core.sv -----
// top level of the probed slot table with frame-based eviction
// instantiates pstfe_ctrl and pstfe_dp; depends on pstfe_pkg
`default_nettype none

// Slot table of 256 entries with bounded linear probing. Each input transfer
// is a lookup of a 32-bit key (tuser 0) or a frame advance (tuser 1). A
// lookup walks up to eight slots from key mod 256, wrapping at the end: a
// matching key is a hit and gets the current frame as its stamp, the first
// empty slot is claimed, and otherwise the slot with the oldest stamp not
// taken this frame is evicted (first one on ties); if all were taken this
// frame the lookup reports no slot. A zero key reports no slot and changes
// nothing. Each input transfer gives exactly one output transfer.
// Timing: one item at a time. A frame advance or zero key goes from the
// input transfer straight to the respond state; a lookup first walks n
// slots (1 to 8) in the probe state, the single read port of the slot
// memory reading one slot per cycle. A new input is
// taken in the cycle after the result is loaded, while that result may still
// wait in the output register. The slot memory needs no clearing pass after
// reset: per-slot valid bits make unwritten slots read as empty.

module probed_slot_table_frame_evict_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [pstfe_pkg::S_DATA_W-1:0] s_axis_tdata,  // [31:0] key
  input  wire logic [pstfe_pkg::S_USER_W-1:0] s_axis_tuser,  // [0] operation
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [pstfe_pkg::M_DATA_W-1:0] m_axis_tdata   // [7:0] slot_index,
                                                              // [9:8] status, zero pad
);
  import pstfe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: idle, walk, respond
  pstfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot memories, frame counter and output register
  pstfe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule : probed_slot_table_frame_evict_core

`default_nettype wire

// ----- sv/pstfe_ctrl.sv -----
// controller state machine of the probed slot table
// depends on pstfe_pkg
`default_nettype none

module pstfe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pstfe_pkg::dp_sts_t sts_i,
  output pstfe_pkg::dp_cmd_t     cmd_o
);
  import pstfe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.direct ? ST_RESP : ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule : pstfe_ctrl

`default_nettype wire

// ----- sv/pstfe_dp.sv -----
// datapath of the probed slot table: slot memories, valid bits, frame
// counter, probe walk registers and output register; depends on pstfe_pkg
`default_nettype none

module pstfe_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [pstfe_pkg::S_DATA_W-1:0] in_data_i,
  input  wire logic [pstfe_pkg::S_USER_W-1:0] in_user_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [pstfe_pkg::M_DATA_W-1:0] out_data_o,
  input  wire pstfe_pkg::dp_cmd_t             cmd_i,
  output pstfe_pkg::dp_sts_t                  sts_o
);
  import pstfe_pkg::*;

  // slot storage: keys and stamps, one read and one write port each
  logic [KEY_W-1:0]   key_mem   [SLOT_COUNT];
  logic [STAMP_W-1:0] stamp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;

  logic [KEY_W-1:0]   key_rd_q;
  logic [STAMP_W-1:0] stamp_rd_q;
  logic               vld_rd_q;

  logic [KEY_W-1:0]   key_q;
  logic [SLOT_W-1:0]  addr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               have_q;
  logic [SLOT_W-1:0]  pick_q;
  logic [STAMP_W-1:0] pick_stamp_q;
  logic [STAMP_W-1:0] frame_q;

  logic [SLOT_W-1:0]  res_slot_q;
  status_e            res_sts_q;

  logic               out_valid_q;
  logic [M_DATA_W-1:0] out_data_q;

  // input decode
  op_e              in_op;
  logic [KEY_W-1:0] in_key;
  logic             in_direct;

  assign in_op     = op_e'(in_user_i[0]);
  assign in_key    = in_data_i[KEY_W-1:0];
  assign in_direct = (in_op == OP_FRAME) || (in_key == '0);

  // slot under test this cycle
  logic [KEY_W-1:0]   cur_key;
  logic [STAMP_W-1:0] cur_stamp;
  logic               hit, empty, cand, last, have_d, claim, done;
  logic [SLOT_W-1:0]  pick_d;
  logic [STAMP_W-1:0] pick_stamp_d;
  logic [SLOT_W-1:0]  wr_addr;
  logic               wr_key_en, wr_stamp_en;
  logic [SLOT_W-1:0]  rd_addr;

  assign cur_key   = vld_rd_q ? key_rd_q : '0;
  assign cur_stamp = vld_rd_q ? stamp_rd_q : '0;

  assign hit   = (cur_key == key_q);
  assign empty = (cur_key == '0);
  assign cand  = (cur_stamp != frame_q) && (!have_q || (cur_stamp < pick_stamp_q));
  assign last  = (cnt_q == CNT_W'(PROBE_WINDOW - 1));

  assign have_d       = have_q | cand;
  assign pick_d       = cand ? addr_q : pick_q;
  assign pick_stamp_d = cand ? cur_stamp : pick_stamp_q;

  // hit beats empty; eviction only at the end of the window
  assign claim = !hit && (empty || (last && have_d));
  assign done  = hit || empty || last;

  assign wr_addr     = (hit || empty) ? addr_q : pick_d;
  assign wr_key_en   = cmd_i.step && claim;
  assign wr_stamp_en = cmd_i.step && (hit || claim);

  assign rd_addr = cmd_i.start ? in_key[SLOT_W-1:0] : SLOT_W'(addr_q + 1'b1);

  // memories
  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= key_q;
    end
    if (wr_stamp_en) begin
      stamp_mem[wr_addr] <= frame_q;
    end
    key_rd_q   <= key_mem[rd_addr];
    stamp_rd_q <= stamp_mem[rd_addr];
    vld_rd_q   <= vld_q[rd_addr];
  end

  // a slot is valid once its key has been written; unwritten slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_key_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // control state of the walk, the frame counter and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= STAMP_W'(1);
      cnt_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
        if (in_op == OP_FRAME) begin
          frame_q <= frame_q + 1'b1;
        end
      end else if (cmd_i.step && !done) begin
        cnt_q  <= cnt_q + 1'b1;
        have_q <= have_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q      <= in_key;
      addr_q     <= in_key[SLOT_W-1:0];
      res_slot_q <= '0;
      res_sts_q  <= (in_op == OP_FRAME) ? STS_FRAME : STS_FULL;
    end else if (cmd_i.step) begin
      if (done) begin
        if (hit) begin
          res_slot_q <= addr_q;
          res_sts_q  <= STS_HIT;
        end else if (claim) begin
          res_slot_q <= wr_addr;
          res_sts_q  <= STS_CLAIM;
        end else begin
          res_slot_q <= '0;
          res_sts_q  <= STS_FULL;
        end
      end else begin
        addr_q       <= SLOT_W'(addr_q + 1'b1);
        pick_q       <= pick_d;
        pick_stamp_q <= pick_stamp_d;
      end
    end
    if (cmd_i.emit) begin
      out_data_q <= M_DATA_W'({res_sts_q, IDX_W'(res_slot_q)});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.direct   = in_direct;
  assign sts_o.done     = done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule : pstfe_dp

`default_nettype wire
